// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the reservation table.
// Depends on a clk and, for RRT_ASSERT, an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define RRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define RRT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rrt_pkg.sv =====
// Types, codes and limits of the resource reservation table.
// Used by rrt_slot_alu, resource_reservation_table and rrt_checker.
package rrt_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [2:0] OP_RESERVE = 3'd0;
  localparam logic [2:0] OP_RELEASE = 3'd1;
  localparam logic [2:0] OP_PROBE   = 3'd2;
  localparam logic [2:0] OP_UPSERT  = 3'd3;
  localparam logic [2:0] OP_REMOVE  = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;

  localparam logic [1:0] REACH_DOWN = 2'd0;
  localparam logic [1:0] REACH_UP   = 2'd1;

  localparam logic [13:0] CORE_LIMIT = 14'd10000;
  localparam logic [9:0]  GPU_LIMIT  = 10'd1000;
  localparam logic [23:0] MB_LIMIT   = 24'd10000000;
  localparam logic [15:0] FAIL_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  slot;
    logic [13:0] core_amount;
    logic [9:0]  gpu_amount;
    logic [23:0] ram_amount;
    logic [23:0] disk_amount;
    logic [13:0] core_floor;
    logic [23:0] ram_floor;
    logic [23:0] disk_floor;
    logic        enable_flag;
    logic        is_online;
    logic [1:0]  reach_result;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] fail_count;
  } out_item_t;

  // One stored table entry, kept in the slot RAM.
  typedef struct packed {
    logic [13:0] core_total;
    logic [9:0]  gpu_total;
    logic [23:0] ram_total;
    logic [23:0] disk_total;
    logic [13:0] core_min_kept;
    logic [23:0] ram_min_kept;
    logic [23:0] disk_min_kept;
    logic [13:0] core_held;
    logic [9:0]  gpu_held;
    logic [23:0] ram_held;
    logic [23:0] disk_held;
    logic [15:0] probe_failures;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic valid;
    logic enabled;
    logic online;
  } slot_flags_t;

  typedef struct packed {
    logic        entry_we;
    entry_t      entry;
    logic        flags_we;
    slot_flags_t flags;
    out_item_t   result;
  } alu_res_t;

  function automatic logic slot_ok(input logic [5:0] s);
    return 32'(s) < NUM_SLOTS;
  endfunction

  function automatic logic [SLOT_AW-1:0] slot_idx(input logic [5:0] s);
    return SLOT_AW'(s);
  endfunction

endpackage

// ===== sv/rrt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rrt_slot_alu.sv =====
// Operation logic for one slot: checks, new entry, new flags and result.
// Depends on rrt_pkg.
module rrt_slot_alu (
  input  rrt_pkg::in_item_t    item,
  input  logic                 in_range,
  input  rrt_pkg::slot_flags_t flags,
  input  rrt_pkg::entry_t      entry,
  output rrt_pkg::alu_res_t    res
);

  always_comb begin
    logic [15:0] core_sum;
    logic [10:0] gpu_sum;
    logic [25:0] ram_sum;
    logic [25:0] disk_sum;
    logic        fits_all;
    logic        bad;
    logic        shrink;
    logic        busy;
    logic        v;

    v = flags.valid;
    core_sum = 16'(entry.core_held) + 16'(entry.core_min_kept) + 16'(item.core_amount);
    gpu_sum  = 11'(entry.gpu_held) + 11'(item.gpu_amount);
    ram_sum  = 26'(entry.ram_held) + 26'(entry.ram_min_kept) + 26'(item.ram_amount);
    disk_sum = 26'(entry.disk_held) + 26'(entry.disk_min_kept) + 26'(item.disk_amount);
    fits_all = (core_sum <= 16'(entry.core_total)) && (gpu_sum <= 11'(entry.gpu_total)) &&
               (ram_sum <= 26'(entry.ram_total)) && (disk_sum <= 26'(entry.disk_total));

    bad = (item.core_amount == 14'd0) || (item.core_amount > rrt_pkg::CORE_LIMIT) ||
          (item.gpu_amount > rrt_pkg::GPU_LIMIT) || (item.ram_amount > rrt_pkg::MB_LIMIT) ||
          (item.disk_amount > rrt_pkg::MB_LIMIT) || (item.core_floor > item.core_amount) ||
          (item.ram_floor > item.ram_amount) || (item.disk_floor > item.disk_amount);

    shrink = (15'(entry.core_held) + 15'(item.core_floor) > 15'(item.core_amount)) ||
             (item.gpu_amount < entry.gpu_held) ||
             (25'(entry.ram_held) + 25'(item.ram_floor) > 25'(item.ram_amount)) ||
             (25'(entry.disk_held) + 25'(item.disk_floor) > 25'(item.disk_amount));

    busy = (entry.core_held != '0) || (entry.gpu_held != '0) ||
           (entry.ram_held != '0) || (entry.disk_held != '0);

    res = '0;
    res.entry = entry;
    res.flags = flags;
    res.result.status = rrt_pkg::ST_INVALID;

    if (in_range) begin
      case (item.op)
        rrt_pkg::OP_RESERVE: begin
          if (v && flags.enabled && flags.online && fits_all) begin
            res.entry.core_held = 14'(core_sum - 16'(entry.core_min_kept));
            res.entry.gpu_held  = 10'(gpu_sum);
            res.entry.ram_held  = 24'(ram_sum - 26'(entry.ram_min_kept));
            res.entry.disk_held = 24'(disk_sum - 26'(entry.disk_min_kept));
            res.entry_we = 1'b1;
            res.result.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_RELEASE: begin
          if (v) begin
            res.entry.core_held = (entry.core_held > item.core_amount) ?
                                  entry.core_held - item.core_amount : '0;
            res.entry.gpu_held  = (entry.gpu_held > item.gpu_amount) ?
                                  entry.gpu_held - item.gpu_amount : '0;
            res.entry.ram_held  = (entry.ram_held > item.ram_amount) ?
                                  entry.ram_held - item.ram_amount : '0;
            res.entry.disk_held = (entry.disk_held > item.disk_amount) ?
                                  entry.disk_held - item.disk_amount : '0;
            res.entry_we = 1'b1;
            res.result.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_PROBE: begin
          if (v) begin
            res.flags.online = item.is_online;
            res.flags_we = 1'b1;
            if (item.reach_result == rrt_pkg::REACH_UP) begin
              res.entry.probe_failures = '0;
            end else if (item.reach_result == rrt_pkg::REACH_DOWN &&
                         entry.probe_failures != rrt_pkg::FAIL_MAX) begin
              res.entry.probe_failures = entry.probe_failures + 16'd1;
            end
            res.entry_we = 1'b1;
            res.result.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_UPSERT: begin
          if (bad) begin
            res.result.status = rrt_pkg::ST_INVALID;
          end else if (v && shrink) begin
            res.result.status = rrt_pkg::ST_CONFLICT;
          end else begin
            if (!v) begin
              res.flags.valid = 1'b1;
              res.flags.online = 1'b0;
              res.entry.core_held = '0;
              res.entry.gpu_held = '0;
              res.entry.ram_held = '0;
              res.entry.disk_held = '0;
              res.entry.probe_failures = '0;
            end
            res.flags.enabled = item.enable_flag;
            res.entry.core_total = item.core_amount;
            res.entry.gpu_total = item.gpu_amount;
            res.entry.ram_total = item.ram_amount;
            res.entry.disk_total = item.disk_amount;
            res.entry.core_min_kept = item.core_floor;
            res.entry.ram_min_kept = item.ram_floor;
            res.entry.disk_min_kept = item.disk_floor;
            res.entry_we = 1'b1;
            res.flags_we = 1'b1;
            res.result.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_REMOVE: begin
          if (v) begin
            if (busy) begin
              res.result.status = rrt_pkg::ST_CONFLICT;
            end else begin
              res.flags.valid = 1'b0;
              res.flags_we = 1'b1;
              res.result.status = rrt_pkg::ST_DONE;
            end
          end
        end
        default: begin
          res.result.status = rrt_pkg::ST_INVALID;
        end
      endcase
    end

    // An empty slot after the op reports no failures.
    res.result.fail_count = (in_range && res.flags.valid) ? res.entry.probe_failures : '0;
  end

endmodule

// ===== sv/resource_reservation_table.sv =====
// Resource reservation table: a table of NUM_SLOTS machine slots, each with totals, floors and
// reserved amounts of cores, GPUs, RAM and disk, plus enabled/online bits and a saturating
// probe-failure counter. Every input transaction (reserve, release, probe update, upsert or
// remove on one slot) produces exactly one result transaction carrying a status and the
// slot's failure count after the op. Throughput is one transaction per cycle while the result
// path is not stalled; an accepted transaction is held in the op-stage register, then moves to
// the result register shown on out_valid when the op stage advances. The rate is set by the
// slot RAM's read-modify-write: the entry is read at acceptance, updated in the op stage
// and written back at the same edge that loads the result register, with a one-deep
// bypass covering back-to-back transactions to the same slot. Valid, enabled and online
// bits live in flip-flops cleared by reset, so no clearing pass is needed after reset; the
// other per-slot fields sit in the RAM and are only used on valid slots.
// Depends on rrt_pkg, rrt_ram and rrt_slot_alu.
module resource_reservation_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrt_pkg::out_item_t out_data
);

  // Flag bits, one per slot
  logic [rrt_pkg::NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [rrt_pkg::NUM_SLOTS-1:0] enabled_r, enabled_nxt;
  logic [rrt_pkg::NUM_SLOTS-1:0] online_r, online_nxt;

  // Op stage (input register)
  logic                s1_valid_r, s1_valid_nxt;
  rrt_pkg::in_item_t   s1_item_r;
  logic                s1_fwd_r;
  rrt_pkg::entry_t     fwd_data_r;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  rrt_pkg::out_item_t  out_data_r;

  logic                        adv;
  logic                        in_acc;
  logic                        commit;
  logic                        wr_en;
  logic [rrt_pkg::SLOT_AW-1:0] in_idx;
  logic [rrt_pkg::SLOT_AW-1:0] s1_idx;
  logic                        s1_in_range;
  logic                        fwd_hit;
  logic [rrt_pkg::ENTRY_W-1:0] ram_rdata;
  rrt_pkg::entry_t             s1_entry;
  rrt_pkg::slot_flags_t        s1_flags;
  rrt_pkg::alu_res_t           alu_res;

  // Advance the op stage whenever the result register is free or being drained.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign commit   = s1_valid_r && adv;

  assign in_idx      = rrt_pkg::slot_idx(in_data.slot);
  assign s1_idx      = rrt_pkg::slot_idx(s1_item_r.slot);
  assign s1_in_range = rrt_pkg::slot_ok(s1_item_r.slot);

  assign wr_en = commit && alu_res.entry_we;

  // The RAM returns the old entry when the read and the write hit the same slot at one
  // edge; flag that case so the op stage takes the written entry instead.
  assign fwd_hit = wr_en && (s1_idx == in_idx);

  rrt_ram #(
    .WIDTH (rrt_pkg::ENTRY_W),
    .DEPTH (rrt_pkg::NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_idx),
    .wdata (alu_res.entry),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  assign s1_entry = s1_fwd_r ? fwd_data_r : rrt_pkg::entry_t'(ram_rdata);

  always_comb begin
    s1_flags = '0;
    if (s1_in_range) begin
      s1_flags.valid   = valid_r[s1_idx];
      s1_flags.enabled = enabled_r[s1_idx];
      s1_flags.online  = online_r[s1_idx];
    end
  end

  rrt_slot_alu u_slot_alu (
    .item     (s1_item_r),
    .in_range (s1_in_range),
    .flags    (s1_flags),
    .entry    (s1_entry),
    .res      (alu_res)
  );

  // Next-state logic for flags and handshake state.
  always_comb begin
    valid_nxt   = valid_r;
    enabled_nxt = enabled_r;
    online_nxt  = online_r;
    if (commit && alu_res.flags_we) begin
      valid_nxt[s1_idx]   = alu_res.flags.valid;
      enabled_nxt[s1_idx] = alu_res.flags.enabled;
      online_nxt[s1_idx]  = alu_res.flags.online;
    end

    // Load on acceptance, drop once the transaction has moved to the result register.
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      enabled_r   <= '0;
      online_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      enabled_r   <= enabled_nxt;
      online_r    <= online_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
      s1_fwd_r  <= fwd_hit;
    end
    // Hold the last written entry; no write happens while the op stage is held.
    if (wr_en) begin
      fwd_data_r <= alu_res.entry;
    end
    if (adv) begin
      out_data_r <= alu_res.result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/rrt_checker.sv =====
// Port-level checker for the resource reservation table, bound to the top level.
// Depends on rrt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input rrt_pkg::out_item_t out_data
);

  `RRT_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `RRT_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result moved")

  `RRT_ASSERT(a_stall_from_out, in_stall |-> out_valid && out_stall, "input stalled, path free")

  `RRT_ASSERT(a_status, out_valid |-> out_data.status <= rrt_pkg::ST_CONFLICT, "undefined status")

endmodule

bind resource_reservation_table rrt_checker u_rrt_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for resource_reservation_table: a shadow copy of the slot table
// predicts status and failure count for every transaction. Depends on rrt_pkg and the RTL.
module testbench;

  localparam int RANDOM_ITEMS = 700;
  localparam int BURST_PROBES = 16;      // back-to-back failure probes on one slot
  localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
  localparam int HOT_SLOTS    = 8;

  // Op and reach codes outside the named set, used to check how they are answered.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] REACH_KEEP  = 2'd2;
  localparam logic [1:0] REACH_SPARE = 2'd3;

  // One queued stimulus transaction plus its pacing: idle cycles before it is offered,
  // receiver stall cycles after its result, and the two pressure markers.
  typedef struct {
    rrt_pkg::in_item_t data;
    int                tx_gap;
    int                rx_gap;
    bit                wait_drain;
    bit                long_hold;
  } table_req_t;

  typedef struct {
    rrt_pkg::out_item_t res;
    int                 rx_gap;
  } result_due_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  rrt_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  rrt_pkg::out_item_t out_data;

  table_req_t  pending_reqs[$];
  result_due_t results_due[$];
  table_req_t  cur_req;

  // Shadow of the slot table.
  rrt_pkg::entry_t      shadow_entry[rrt_pkg::NUM_SLOTS];
  rrt_pkg::slot_flags_t shadow_flags[rrt_pkg::NUM_SLOTS];

  bit  req_taken;
  bit  long_hold_req;
  int  tx_idle_left;
  int  rx_idle_left;
  int  long_hold_left;
  int  calm_left;
  int  errors;
  int  done_cnt, invalid_cnt, conflict_cnt, backpressure_cycles;
  int  peak_fail;

  resource_reservation_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table model
  // ---------------------------------------------------------------------------

  // True when want fits in total - used - kept; wide enough never to wrap.
  function automatic bit has_room(input longint unsigned total, used, kept, want);
    return used + kept + want <= total;
  endfunction

  function automatic longint unsigned sub_to_zero(input longint unsigned a, b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  // Apply one transaction to the shadow table and return the result it must produce.
  function automatic rrt_pkg::out_item_t apply_table_op(input rrt_pkg::in_item_t t);
    rrt_pkg::entry_t      e;
    rrt_pkg::slot_flags_t f;
    rrt_pkg::out_item_t   r;
    bit                   bad;
    r.status = rrt_pkg::ST_INVALID;
    r.fail_count = '0;
    if (32'(t.slot) < rrt_pkg::NUM_SLOTS) begin
      e = shadow_entry[t.slot];
      f = shadow_flags[t.slot];
      case (t.op)
        rrt_pkg::OP_RESERVE: begin
          // All four kinds are granted together or not at all.
          if (f.valid && f.enabled && f.online &&
              has_room(64'(e.core_total), 64'(e.core_held), 64'(e.core_min_kept),
                       64'(t.core_amount)) &&
              has_room(64'(e.gpu_total), 64'(e.gpu_held), 64'd0, 64'(t.gpu_amount)) &&
              has_room(64'(e.ram_total), 64'(e.ram_held), 64'(e.ram_min_kept),
                       64'(t.ram_amount)) &&
              has_room(64'(e.disk_total), 64'(e.disk_held), 64'(e.disk_min_kept),
                       64'(t.disk_amount))) begin
            e.core_held = e.core_held + t.core_amount;
            e.gpu_held  = e.gpu_held + t.gpu_amount;
            e.ram_held  = e.ram_held + t.ram_amount;
            e.disk_held = e.disk_held + t.disk_amount;
            r.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_RELEASE: begin
          if (f.valid) begin
            e.core_held = 14'(sub_to_zero(64'(e.core_held), 64'(t.core_amount)));
            e.gpu_held  = 10'(sub_to_zero(64'(e.gpu_held), 64'(t.gpu_amount)));
            e.ram_held  = 24'(sub_to_zero(64'(e.ram_held), 64'(t.ram_amount)));
            e.disk_held = 24'(sub_to_zero(64'(e.disk_held), 64'(t.disk_amount)));
            r.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_PROBE: begin
          if (f.valid) begin
            f.online = t.is_online;
            if (t.reach_result == rrt_pkg::REACH_UP)
              e.probe_failures = '0;
            else if (t.reach_result == rrt_pkg::REACH_DOWN &&
                     e.probe_failures != rrt_pkg::FAIL_MAX)
              e.probe_failures = e.probe_failures + 16'd1;
            r.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_UPSERT: begin
          bad = t.core_amount < 14'd1 || t.core_amount > rrt_pkg::CORE_LIMIT ||
                t.gpu_amount > rrt_pkg::GPU_LIMIT || t.ram_amount > rrt_pkg::MB_LIMIT ||
                t.disk_amount > rrt_pkg::MB_LIMIT || t.core_floor > t.core_amount ||
                t.ram_floor > t.ram_amount || t.disk_floor > t.disk_amount;
          if (bad) begin
            r.status = rrt_pkg::ST_INVALID;
          end else if (f.valid &&
                       (!has_room(64'(t.core_amount), 64'(e.core_held),
                                  64'(t.core_floor), 64'd0) ||
                        t.gpu_amount < e.gpu_held ||
                        !has_room(64'(t.ram_amount), 64'(e.ram_held),
                                  64'(t.ram_floor), 64'd0) ||
                        !has_room(64'(t.disk_amount), 64'(e.disk_held),
                                  64'(t.disk_floor), 64'd0))) begin
            r.status = rrt_pkg::ST_CONFLICT;
          end else begin
            if (!f.valid) begin
              f.valid = 1'b1;
              f.online = 1'b0;
              e.core_held = '0;
              e.gpu_held = '0;
              e.ram_held = '0;
              e.disk_held = '0;
              e.probe_failures = '0;
            end
            f.enabled = t.enable_flag;
            e.core_total = t.core_amount;
            e.gpu_total = t.gpu_amount;
            e.ram_total = t.ram_amount;
            e.disk_total = t.disk_amount;
            e.core_min_kept = t.core_floor;
            e.ram_min_kept = t.ram_floor;
            e.disk_min_kept = t.disk_floor;
            r.status = rrt_pkg::ST_DONE;
          end
        end
        rrt_pkg::OP_REMOVE: begin
          if (f.valid) begin
            if (e.core_held != '0 || e.gpu_held != '0 ||
                e.ram_held != '0 || e.disk_held != '0) begin
              r.status = rrt_pkg::ST_CONFLICT;
            end else begin
              f.valid = 1'b0;
              r.status = rrt_pkg::ST_DONE;
            end
          end
        end
        default: ;
      endcase
      shadow_entry[t.slot] = e;
      shadow_flags[t.slot] = f;
      r.fail_count = f.valid ? e.probe_failures : 16'd0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  function automatic rrt_pkg::in_item_t blank_op(input logic [2:0] op,
                                                 input int unsigned slot);
    rrt_pkg::in_item_t t;
    t = '0;
    t.op = op;
    t.slot = 6'(slot);
    return t;
  endfunction

  function automatic rrt_pkg::in_item_t upsert_op(input int unsigned slot, cores, gpus, ram,
                                                  disk, cfl, rfl, dfl, input bit en);
    rrt_pkg::in_item_t t;
    t = blank_op(rrt_pkg::OP_UPSERT, slot);
    t.core_amount = 14'(cores);
    t.gpu_amount = 10'(gpus);
    t.ram_amount = 24'(ram);
    t.disk_amount = 24'(disk);
    t.core_floor = 14'(cfl);
    t.ram_floor = 24'(rfl);
    t.disk_floor = 24'(dfl);
    t.enable_flag = en;
    return t;
  endfunction

  function automatic rrt_pkg::in_item_t amount_op(input logic [2:0] op,
                                                  input int unsigned slot,
                                                  cores, gpus, ram, disk);
    rrt_pkg::in_item_t t;
    t = blank_op(op, slot);
    t.core_amount = 14'(cores);
    t.gpu_amount = 10'(gpus);
    t.ram_amount = 24'(ram);
    t.disk_amount = 24'(disk);
    return t;
  endfunction

  function automatic rrt_pkg::in_item_t probe_op(input int unsigned slot, input bit onl,
                                                 input logic [1:0] reach);
    rrt_pkg::in_item_t t;
    t = blank_op(rrt_pkg::OP_PROBE, slot);
    t.is_online = onl;
    t.reach_result = reach;
    return t;
  endfunction

  // Random transaction: start from full-width noise in every field, then shape the
  // fields that the chosen op reads so most sequences stay well formed.
  function automatic rrt_pkg::in_item_t random_item();
    rrt_pkg::in_item_t t;
    int unsigned       pick;
    t.op = 3'($urandom);
    t.slot = 6'($urandom);
    t.core_amount = 14'($urandom);
    t.gpu_amount = 10'($urandom);
    t.ram_amount = 24'($urandom);
    t.disk_amount = 24'($urandom);
    t.core_floor = 14'($urandom);
    t.ram_floor = 24'($urandom);
    t.disk_floor = 24'($urandom);
    t.enable_flag = 1'($urandom);
    t.is_online = 1'($urandom);
    t.reach_result = 2'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 90) return t;   // leave as noise, unused op codes included
    t.slot = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, HOT_SLOTS - 1))
                                        : 6'($urandom_range(0, rrt_pkg::NUM_SLOTS - 1));
    if (pick < 45) begin
      t.op = (pick < 30) ? rrt_pkg::OP_RESERVE : rrt_pkg::OP_RELEASE;
      if ($urandom_range(0, 7) == 0) begin
        t.core_amount = 14'($urandom_range(0, 32'(rrt_pkg::CORE_LIMIT)));
        t.gpu_amount = 10'($urandom_range(0, 32'(rrt_pkg::GPU_LIMIT)));
        t.ram_amount = 24'($urandom_range(0, 32'(rrt_pkg::MB_LIMIT)));
        t.disk_amount = 24'($urandom_range(0, 32'(rrt_pkg::MB_LIMIT)));
      end else begin
        t.core_amount = 14'($urandom_range(0, 400));
        t.gpu_amount = 10'($urandom_range(0, 40));
        t.ram_amount = 24'($urandom_range(0, 400000));
        t.disk_amount = 24'($urandom_range(0, 400000));
      end
    end else if (pick < 60) begin
      t.op = rrt_pkg::OP_PROBE;
      t.is_online = ($urandom_range(0, 9) < 8);
    end else if (pick < 80) begin
      t.op = rrt_pkg::OP_UPSERT;
      if ($urandom_range(0, 7) != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          t.core_amount = rrt_pkg::CORE_LIMIT;
          t.gpu_amount = rrt_pkg::GPU_LIMIT;
          t.ram_amount = rrt_pkg::MB_LIMIT;
          t.disk_amount = rrt_pkg::MB_LIMIT;
        end else begin
          t.core_amount = 14'($urandom_range(1, 32'(rrt_pkg::CORE_LIMIT)));
          t.gpu_amount = 10'($urandom_range(0, 32'(rrt_pkg::GPU_LIMIT)));
          t.ram_amount = 24'($urandom_range(0, 32'(rrt_pkg::MB_LIMIT)));
          t.disk_amount = 24'($urandom_range(0, 32'(rrt_pkg::MB_LIMIT)));
        end
        t.core_floor = 14'($urandom_range(0, 32'(t.core_amount) / 8));
        t.ram_floor = 24'($urandom_range(0, 32'(t.ram_amount) / 8));
        t.disk_floor = 24'($urandom_range(0, 32'(t.disk_amount) / 8));
        t.enable_flag = ($urandom_range(0, 19) < 17);
      end
    end else begin
      t.op = rrt_pkg::OP_REMOVE;
    end
    return t;
  endfunction

  task automatic add_req(input rrt_pkg::in_item_t t, input int tx_gap, rx_gap,
                         input bit wait_drain, long_hold);
    table_req_t q;
    q.data = t;
    q.tx_gap = tx_gap;
    q.rx_gap = rx_gap;
    q.wait_drain = wait_drain;
    q.long_hold = long_hold;
    pending_reqs.push_back(q);
  endtask

  // Directed item with random pacing.
  task automatic add_directed(input rrt_pkg::in_item_t t);
    add_req(t, $urandom_range(0, 16), $urandom_range(0, 16), 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    rrt_pkg::in_item_t t;
    int                tx, rx;
    for (int i = 0; i < rrt_pkg::NUM_SLOTS; i++) begin
      shadow_entry[i] = '0;
      shadow_flags[i] = '0;
    end

    // Empty slot: everything but upsert is refused.
    add_directed(amount_op(rrt_pkg::OP_RESERVE, 5, 1, 1, 1, 1));
    add_directed(probe_op(5, 1'b1, rrt_pkg::REACH_DOWN));
    add_directed(blank_op(rrt_pkg::OP_REMOVE, 5));
    // Invalid upserts: zero cores, each total over its limit, each floor over its total.
    add_directed(upsert_op(0, 0, 10, 100, 100, 0, 0, 0, 1'b1));
    add_directed(upsert_op(0, 16383, 10, 100, 100, 0, 0, 0, 1'b1));
    add_directed(upsert_op(0, 1, 1001, 100, 100, 0, 0, 0, 1'b1));
    add_directed(upsert_op(0, 1, 10, 10000001, 100, 0, 0, 0, 1'b1));
    add_directed(upsert_op(0, 1, 10, 100, 16777215, 0, 0, 0, 1'b1));
    add_directed(upsert_op(0, 10, 10, 100, 100, 11, 0, 0, 1'b1));
    add_directed(upsert_op(0, 10, 10, 100, 100, 0, 101, 0, 1'b1));
    add_directed(upsert_op(0, 10, 10, 100, 100, 0, 0, 101, 1'b1));
    // Insert at the limits, then exercise it while offline and online.
    add_directed(upsert_op(0, 10000, 1000, 10000000, 10000000, 100, 1000, 1000, 1'b1));
    add_directed(amount_op(rrt_pkg::OP_RESERVE, 0, 1, 0, 0, 0));
    add_directed(probe_op(0, 1'b1, rrt_pkg::REACH_DOWN));
    add_directed(probe_op(0, 1'b1, REACH_SPARE));
    add_directed(amount_op(rrt_pkg::OP_RESERVE, 0, 9900, 1000, 9999000, 9999000));
    add_directed(amount_op(rrt_pkg::OP_RESERVE, 0, 1, 0, 0, 0));
    add_directed(upsert_op(0, 9999, 1000, 10000000, 10000000, 100, 1000, 1000, 1'b1));
    add_directed(blank_op(rrt_pkg::OP_REMOVE, 0));
    add_directed(amount_op(rrt_pkg::OP_RELEASE, 0, 16383, 1023, 16777215, 16777215));
    add_directed(probe_op(0, 1'b0, rrt_pkg::REACH_UP));
    add_directed(blank_op(rrt_pkg::OP_REMOVE, 0));
    // Disabled slot refuses, replacement keeps reservations, unused op codes refuse.
    add_directed(upsert_op(1, 100, 10, 1000, 1000, 0, 0, 0, 1'b0));
    add_directed(probe_op(1, 1'b1, REACH_KEEP));
    add_directed(amount_op(rrt_pkg::OP_RESERVE, 1, 10, 1, 10, 10));
    add_directed(upsert_op(1, 100, 10, 1000, 1000, 0, 0, 0, 1'b1));
    add_directed(amount_op(rrt_pkg::OP_RESERVE, 1, 10, 1, 10, 10));
    add_directed(upsert_op(1, 50, 10, 1000, 1000, 5, 5, 5, 1'b1));
    add_directed(blank_op(OP_SPARE_HI, 1));
    add_directed(blank_op(OP_SPARE_LO, 9));

    // Count failures on one slot with probes back to back.
    add_req(upsert_op(63, 10, 10, 10, 10, 0, 0, 0, 1'b1), 0, 0, 1'b1, 1'b0);
    for (int i = 0; i < BURST_PROBES; i++)
      add_req(probe_op(63, 1'b1, rrt_pkg::REACH_DOWN), 0, 0, 1'b0, 1'b0);

    // Random phase with calm bursts, one long receiver hold-off and two full drains.
    calm_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (calm_left > 0) begin
        calm_left--;
        tx = 0;
        rx = 0;
      end else begin
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
        tx = $urandom_range(0, 16);
        rx = $urandom_range(0, 16);
      end
      // Keep the sender busy while the receiver is held off so the block backs up.
      if (i >= 250 && i < 290) tx = 0;
      t = random_item();
      add_req(t, tx, rx, (i == 0) || (i == 500), (i == 250));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all stimulus to go in and all results to come out, then let the
    // pipeline settle so any stray result gets flagged.
    while (pending_reqs.size() != 0 || in_valid || results_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d transactions: %0d done, %0d refused, %0d conflicts.",
             done_cnt + invalid_cnt + conflict_cnt, done_cnt, invalid_cnt, conflict_cnt);
    $display("Input back-pressure seen on %0d cycles; peak failure count %0d.",
             backpressure_cycles, peak_fail);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("%0t: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // Sample the input handshake: predict each accepted transaction and queue its result.
  always @(posedge clk) begin : accept_input
    result_due_t due;
    if (rst_n && in_valid) begin
      if (in_stall) begin
        backpressure_cycles++;
      end else begin
        due.res = apply_table_op(in_data);
        due.rx_gap = cur_req.rx_gap;
        results_due.push_back(due);
        if (cur_req.long_hold) long_hold_req = 1'b1;
        req_taken = 1'b1;
      end
    end
  end

  // Present the next transaction at the falling edge; hold a stalled payload unchanged.
  always @(negedge clk) begin : drive_input
    bit offer;
    offer = 1'b0;
    if (!rst_n) begin
      offer = 1'b0;
    end else if (in_valid && !req_taken) begin
      offer = 1'b1;
    end else begin
      req_taken = 1'b0;
      if (tx_idle_left > 0) begin
        tx_idle_left--;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].wait_drain && results_due.size() != 0)) begin
        cur_req = pending_reqs.pop_front();
        in_data <= cur_req.data;
        offer = 1'b1;
        // Arm the idle gap that precedes the following transaction.
        tx_idle_left = (pending_reqs.size() != 0) ? pending_reqs[0].tx_gap : 0;
      end
    end
    in_valid <= offer;
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_due_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d fail_count %0d",
                 $time, out_data.status, out_data.fail_count);
      end else begin
        due = results_due.pop_front();
        if (out_data.status !== due.res.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, due.res.status, out_data.status);
        end
        if (out_data.fail_count !== due.res.fail_count) begin
          errors++;
          $display("%0t: fail_count mismatch, expected %0d, actual %0d",
                   $time, due.res.fail_count, out_data.fail_count);
        end
        case (due.res.status)
          rrt_pkg::ST_DONE:     done_cnt++;
          rrt_pkg::ST_CONFLICT: conflict_cnt++;
          default:              invalid_cnt++;
        endcase
        if (int'(due.res.fail_count) > peak_fail) peak_fail = int'(due.res.fail_count);
        rx_idle_left = due.rx_gap;
      end
    end
  end

  // Drive out_stall: the long hold-off takes priority over the per-result stall.
  always @(negedge clk) begin : drive_stall
    bit stall_now;
    stall_now = 1'b0;
    if (long_hold_req) begin
      long_hold_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (long_hold_left > 0) begin
      long_hold_left--;
      stall_now = 1'b1;
    end else if (rx_idle_left > 0) begin
      rx_idle_left--;
      stall_now = 1'b1;
    end
    out_stall <= stall_now;
  end

endmodule
